/* hdl/pwfp_pkg.sv */
// Shared types and codes for the wire format field parser.
package pwfp_pkg;

    // Longest varint accepted, in bytes
    localparam int MAX_VARINT_BYTES = 10;

    // Result queue depth
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result kinds
    localparam logic [1:0] RK_SCALAR = 2'd0;
    localparam logic [1:0] RK_HEADER = 2'd1;
    localparam logic [1:0] RK_BYTE   = 2'd2;
    localparam logic [1:0] RK_ERROR  = 2'd3;

    // Error codes
    localparam logic [2:0] EC_NONE      = 3'd0;
    localparam logic [2:0] EC_TRUNC     = 3'd1;
    localparam logic [2:0] EC_OVERFLOW  = 3'd2;
    localparam logic [2:0] EC_NUM_ZERO  = 3'd3;
    localparam logic [2:0] EC_GROUP     = 3'd4;
    localparam logic [2:0] EC_BAD_TYPE  = 3'd5;
    localparam logic [2:0] EC_FIX_TRUNC = 3'd6;

    // Wire types
    localparam logic [2:0] WT_VARINT    = 3'd0;
    localparam logic [2:0] WT_FIXED64   = 3'd1;
    localparam logic [2:0] WT_LEN       = 3'd2;
    localparam logic [2:0] WT_GRP_START = 3'd3;
    localparam logic [2:0] WT_GRP_END   = 3'd4;
    localparam logic [2:0] WT_FIXED32   = 3'd5;

    typedef enum logic [2:0] {
        PH_KEY     = 3'd0,
        PH_VARVAL  = 3'd1,
        PH_FIXED   = 3'd2,
        PH_LENVAR  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DRAIN   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] field_number;
        logic [2:0]  wire_kind;
        logic [63:0] scalar_value;
        logic        payload_last;
        logic [2:0]  error_code;
        logic        last_in_step;
    } result_t;

    // Results produced by one byte: count of 0..2, then the slots in order
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

/* hdl/pwfp_decode.sv */
// Input register, parse state and per-byte decode of the wire format.
module pwfp_decode
    import pwfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       message_end,
    input  logic       room,
    output push_t      push
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg;
    logic        end_reg;
    logic        fire;

    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  idx_reg, idx_next;
    logic [31:0] num_reg, num_next;
    logic [2:0]  wire_reg, wire_next;
    logic [3:0]  fl_reg, fl_next;
    logic [63:0] pl_reg, pl_next;

    // Varint byte decode
    logic [70:0] vi_sh;
    logic [63:0] acc_v;
    logic        vi_done;
    logic        vi_ovf;
    logic [31:0] key_num;
    logic [2:0]  key_wire;

    // Fixed byte decode
    logic [3:0]  fx_total;
    logic [3:0]  fx_left;
    logic [3:0]  fx_pos;
    logic [3:0]  fx_left_new;
    logic [63:0] acc_f;
    logic        pl_le1;

    // Classified results of this byte
    logic        d_valid;
    logic [1:0]  d_kind;
    logic [63:0] d_val;
    logic        d_last;
    logic        e_valid;
    logic [2:0]  e_code;
    logic [31:0] e_num;
    logic [2:0]  e_wire;
    result_t     d_res, e_res;

    // Take a new request when the register is empty or its byte is decoded now
    assign fire          = in_valid_reg && room;
    assign in_stall      = in_valid_reg && !room;
    assign in_valid_next = (in_valid && !in_stall) || (in_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
            end_reg  <= message_end;
        end
    end

    // Varint step: merge seven bits, detect completion and excess length
    assign vi_sh    = {64'b0, byte_reg[6:0]} << ({3'b0, idx_reg} * 7'd7);
    assign acc_v    = acc_reg | vi_sh[63:0];
    assign vi_done  = !byte_reg[7];
    assign vi_ovf   = byte_reg[7] && (({1'b0, idx_reg} + 5'd1) >= 5'(MAX_VARINT_BYTES));
    assign key_num  = acc_v[34:3];
    assign key_wire = acc_v[2:0];

    // Fixed step: place the byte at its little-endian position
    assign fx_total    = (wire_reg == WT_FIXED64) ? 4'd8 : 4'd4;
    assign fx_left     = (fl_reg == 4'd0 || fl_reg > fx_total) ? fx_total : fl_reg;
    assign fx_pos      = fx_total - fx_left;
    assign acc_f       = acc_reg | ({56'b0, byte_reg} << {fx_pos[2:0], 3'b0});
    assign fx_left_new = fx_left - 4'd1;
    assign pl_le1      = (pl_reg <= 64'd1);

    // Classify the byte into an optional data result and an optional error
    always_comb
    begin
        d_valid = 1'b0;
        d_kind  = RK_SCALAR;
        d_val   = 64'd0;
        d_last  = 1'b0;
        e_valid = 1'b0;
        e_code  = EC_NONE;
        e_num   = num_reg;
        e_wire  = wire_reg;
        case (phase_reg)
            PH_KEY:
            begin
                e_num  = 32'd0;
                e_wire = 3'd0;
                if (vi_ovf)
                begin
                    e_valid = 1'b1;
                    e_code  = EC_OVERFLOW;
                end
                else if (!vi_done)
                begin
                    e_valid = end_reg;
                    e_code  = EC_TRUNC;
                end
                else if (key_num == 32'd0)
                begin
                    e_valid = 1'b1;
                    e_code  = EC_NUM_ZERO;
                    e_wire  = key_wire;
                end
                else
                begin
                    e_num  = key_num;
                    e_wire = key_wire;
                    if (key_wire inside {WT_GRP_START, WT_GRP_END})
                    begin
                        e_valid = 1'b1;
                        e_code  = EC_GROUP;
                    end
                    else if (key_wire inside {WT_VARINT, WT_LEN})
                    begin
                        e_valid = end_reg;
                        e_code  = EC_TRUNC;
                    end
                    else if (key_wire inside {WT_FIXED64, WT_FIXED32})
                    begin
                        e_valid = end_reg;
                        e_code  = EC_FIX_TRUNC;
                    end
                    else
                    begin
                        e_valid = 1'b1;
                        e_code  = EC_BAD_TYPE;
                    end
                end
            end
            PH_VARVAL, PH_LENVAR:
            begin
                if (vi_ovf)
                begin
                    e_valid = 1'b1;
                    e_code  = EC_OVERFLOW;
                end
                else if (!vi_done)
                begin
                    e_valid = end_reg;
                    e_code  = EC_TRUNC;
                end
                else
                begin
                    d_valid = 1'b1;
                    d_kind  = (phase_reg == PH_VARVAL) ? RK_SCALAR : RK_HEADER;
                    d_val   = acc_v;
                    e_valid = (phase_reg == PH_LENVAR) && (acc_v != 64'd0) && end_reg;
                    e_code  = EC_FIX_TRUNC;
                end
            end
            PH_FIXED:
            begin
                if (fx_left_new == 4'd0)
                begin
                    d_valid = 1'b1;
                    d_kind  = RK_SCALAR;
                    d_val   = acc_f;
                end
                else
                begin
                    e_valid = end_reg;
                    e_code  = EC_FIX_TRUNC;
                end
            end
            PH_PAYLOAD:
            begin
                d_valid = 1'b1;
                d_kind  = RK_BYTE;
                d_val   = {56'b0, byte_reg};
                d_last  = pl_le1;
                e_valid = !pl_le1 && end_reg;
                e_code  = EC_FIX_TRUNC;
            end
            default:
            begin
                // drain: drop the byte
            end
        endcase
    end

    // Assemble the results of this byte in order
    always_comb
    begin
        d_res = '{result_kind: d_kind, field_number: num_reg, wire_kind: wire_reg,
                  scalar_value: d_val, payload_last: d_last, error_code: EC_NONE,
                  last_in_step: !e_valid};
        e_res = '{result_kind: RK_ERROR, field_number: e_num, wire_kind: e_wire,
                  scalar_value: 64'd0, payload_last: 1'b0, error_code: e_code,
                  last_in_step: 1'b1};
        push.cnt = 2'd0;
        push.r0  = e_res;
        push.r1  = e_res;
        if (fire)
        begin
            push.cnt = {1'b0, d_valid} + {1'b0, e_valid};
            if (d_valid)
            begin
                push.r0 = d_res;
            end
        end
    end

    // Next parse state
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        idx_next   = idx_reg;
        num_next   = num_reg;
        wire_next  = wire_reg;
        fl_next    = fl_reg;
        pl_next    = pl_reg;
        if (fire)
        begin
            // latch a completed key, also when it turns out to be bad
            if (phase_reg == PH_KEY && vi_done)
            begin
                num_next  = key_num;
                wire_next = key_wire;
            end
            if (e_valid)
            begin
                acc_next   = 64'd0;
                idx_next   = 4'd0;
                fl_next    = 4'd0;
                pl_next    = 64'd0;
                phase_next = PH_DRAIN;
            end
            else
            begin
                case (phase_reg)
                    PH_KEY, PH_VARVAL, PH_LENVAR:
                    begin
                        if (!vi_done)
                        begin
                            acc_next = acc_v;
                            idx_next = idx_reg + 4'd1;
                        end
                        else
                        begin
                            acc_next   = 64'd0;
                            idx_next   = 4'd0;
                            fl_next    = 4'd0;
                            pl_next    = 64'd0;
                            phase_next = PH_KEY;
                            if (phase_reg == PH_KEY)
                            begin
                                case (key_wire)
                                    WT_VARINT:
                                    begin
                                        phase_next = PH_VARVAL;
                                    end
                                    WT_FIXED64:
                                    begin
                                        phase_next = PH_FIXED;
                                        fl_next    = 4'd8;
                                    end
                                    WT_FIXED32:
                                    begin
                                        phase_next = PH_FIXED;
                                        fl_next    = 4'd4;
                                    end
                                    WT_LEN:
                                    begin
                                        phase_next = PH_LENVAR;
                                    end
                                    default:
                                    begin
                                        phase_next = PH_DRAIN;
                                    end
                                endcase
                            end
                            else if (phase_reg == PH_LENVAR && acc_v != 64'd0)
                            begin
                                pl_next    = acc_v;
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_FIXED:
                    begin
                        if (fx_left_new == 4'd0)
                        begin
                            acc_next   = 64'd0;
                            idx_next   = 4'd0;
                            fl_next    = 4'd0;
                            pl_next    = 64'd0;
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            acc_next = acc_f;
                            fl_next  = fx_left_new;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (pl_le1)
                        begin
                            pl_next    = 64'd0;
                            acc_next   = 64'd0;
                            idx_next   = 4'd0;
                            fl_next    = 4'd0;
                            phase_next = PH_KEY;
                        end
                        else
                        begin
                            pl_next = pl_reg - 64'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
            // message end: back to awaiting a key with work cleared
            if (end_reg)
            begin
                acc_next   = 64'd0;
                idx_next   = 4'd0;
                fl_next    = 4'd0;
                pl_next    = 64'd0;
                phase_next = PH_KEY;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KEY;
            acc_reg   <= 64'd0;
            idx_reg   <= 4'd0;
            num_reg   <= 32'd0;
            wire_reg  <= 3'd0;
            fl_reg    <= 4'd0;
            pl_reg    <= 64'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
            num_reg   <= num_next;
            wire_reg  <= wire_next;
            fl_reg    <= fl_next;
            pl_reg    <= pl_next;
        end
    end

endmodule

/* hdl/pwfp_outq.sv */
// Result queue: takes up to two results a cycle, gives one a cycle while out_stall is low.
module pwfp_outq
    import pwfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic              out_valid,
    input  logic              out_stall,
    output result_t           head,
    output logic [QCNT_W-1:0] count
);

    result_t             ent_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = ent_reg[rptr_reg];
    assign count     = cnt_reg;

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next = wptr_reg + QPTR_W'(push.cnt);
        rptr_next = rptr_reg + QPTR_W'(pop);
        cnt_next  = cnt_reg + QCNT_W'(push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Write the new results in order
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            ent_reg[wptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            ent_reg[wptr_reg + QPTR_W'(1)] <= push.r1;
        end
    end

endmodule

/* hdl/protobuf_wire_field_parser.sv */
// Throughput: one byte per cycle; the input register holds its byte while the result queue
// holds three or more results. A byte that yields two results (header or data followed by
// an error) writes both at once into a four-entry result queue, which hands them out in order.
// Reset (rst_n low, asynchronous) clears the input valid flag, the parse state and the queue
// pointers and count, and returns to awaiting a key.
module protobuf_wire_field_parser
    import pwfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [31:0] field_number,
    output logic [2:0]  wire_kind,
    output logic [63:0] scalar_value,
    output logic        payload_last,
    output logic [2:0]  error_code,
    output logic        last_in_step
);

    push_t             push;
    result_t           head;
    logic [QCNT_W-1:0] q_count;
    logic              room;

    // Decode only when the queue can take two more results
    assign room = (q_count <= QCNT_W'(QDEPTH - 2));

    pwfp_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .message_end (message_end),
        .room        (room),
        .push        (push)
    );

    pwfp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .count     (q_count)
    );

    assign result_kind  = head.result_kind;
    assign field_number = head.field_number;
    assign wire_kind    = head.wire_kind;
    assign scalar_value = head.scalar_value;
    assign payload_last = head.payload_last;
    assign error_code   = head.error_code;
    assign last_in_step = head.last_in_step;

`ifndef ASSERT_OFF
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("result queue overfilled");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd3)
        else $error("more than two results from one byte");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> (push.r1.result_kind == RK_ERROR) && push.r1.last_in_step
                             && !push.r0.last_in_step)
        else $error("two-result request not data then error");

    a_room_push: assert property (@(posedge clk) disable iff (!rst_n)
        !room |-> push.cnt == 2'd0)
        else $error("results written without queue room");
`endif

endmodule

/* dv/wire_field_checker.sv */
`timescale 1ns / 100ps
// Field parser checker: watches both channels, predicts the decoded results and compares them.
module wire_field_checker
    import pwfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        message_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  result_kind,
    input  logic [31:0] field_number,
    input  logic [2:0]  wire_kind,
    input  logic [63:0] scalar_value,
    input  logic        payload_last,
    input  logic [2:0]  error_code,
    input  logic        last_in_step,
    output int          mismatch_count,
    output int          results_owed,
    output int          decoded_count
);

    typedef enum logic [1:0] {
        VARINT_MORE,
        VARINT_DONE,
        VARINT_OVER
    } varint_status_t;

    // Decoder state
    phase_t      phase;
    logic [63:0] accum;
    int          vbyte_idx;
    logic [31:0] key_number;
    logic [2:0]  key_wt;
    int          fixed_left;
    logic [63:0] payload_left;

    // Results of the request being decoded, then the ones still owed by the block
    result_t     step_res [2];
    int          step_cnt;
    result_t     owed_results [$];
    result_t     want;

    function automatic void clear_work();
        accum        = '0;
        vbyte_idx    = 0;
        fixed_left   = 0;
        payload_left = '0;
    endfunction

    function automatic void go_key();
        clear_work();
        phase = PH_KEY;
    endfunction

    // Queue one predicted result behind the ones already owed
    function automatic void owe_result(result_t r);
        owed_results = {owed_results, r};
    endfunction

    // Fold one varint byte into the accumulator; bits past bit 63 fall off
    function automatic varint_status_t varint_step(logic [7:0] b);
        if (vbyte_idx < 10)
            accum |= {57'd0, b[6:0]} << (7 * vbyte_idx);
        if (!b[7])
            return VARINT_DONE;
        vbyte_idx++;
        if (vbyte_idx >= MAX_VARINT_BYTES)
            return VARINT_OVER;
        return VARINT_MORE;
    endfunction

    function automatic void add_result(logic [1:0] kind, logic [31:0] num, logic [2:0] wt,
                                       logic [63:0] val, logic last, logic [2:0] code);
        result_t r;
        r.result_kind  = kind;
        r.field_number = num;
        r.wire_kind    = wt;
        r.scalar_value = val;
        r.payload_last = last;
        r.error_code   = code;
        r.last_in_step = 1'b0;
        step_res[step_cnt] = r;
        step_cnt++;
    endfunction

    // Report an error, then drop bytes until the message ends
    function automatic void raise_error(logic [2:0] code, logic [31:0] num, logic [2:0] wt,
                                        logic fin);
        add_result(RK_ERROR, num, wt, '0, 1'b0, code);
        clear_work();
        phase = fin ? PH_KEY : PH_DRAIN;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic fin);
        varint_status_t vs;
        logic [63:0]    key;
        logic [63:0]    len;
        int             total;
        int             pos;
        logic           is_last_byte;
        step_cnt = 0;
        case (phase)
            PH_KEY: begin
                vs = varint_step(b);
                if (vs == VARINT_OVER)
                    raise_error(EC_OVERFLOW, '0, '0, fin);
                else if (vs == VARINT_MORE) begin
                    if (fin)
                        raise_error(EC_TRUNC, '0, '0, fin);
                end
                else begin
                    key = accum;
                    clear_work();
                    key_wt     = key[2:0];
                    key_number = key[34:3];
                    if (key_number == 0)
                        raise_error(EC_NUM_ZERO, '0, key_wt, fin);
                    else begin
                        case (key_wt)
                            WT_VARINT:  phase = PH_VARVAL;
                            WT_LEN:     phase = PH_LENVAR;
                            WT_FIXED64:
                            begin
                                phase      = PH_FIXED;
                                fixed_left = 8;
                            end
                            WT_FIXED32:
                            begin
                                phase      = PH_FIXED;
                                fixed_left = 4;
                            end
                            WT_GRP_START, WT_GRP_END:
                                raise_error(EC_GROUP, key_number, key_wt, fin);
                            default:
                                raise_error(EC_BAD_TYPE, key_number, key_wt, fin);
                        endcase
                        // message ends right after a usable key
                        if (step_cnt == 0 && fin)
                            raise_error((phase == PH_FIXED) ? EC_FIX_TRUNC : EC_TRUNC,
                                        key_number, key_wt, fin);
                    end
                end
            end
            PH_VARVAL, PH_LENVAR: begin
                vs = varint_step(b);
                if (vs == VARINT_OVER)
                    raise_error(EC_OVERFLOW, key_number, key_wt, fin);
                else if (vs == VARINT_MORE) begin
                    if (fin)
                        raise_error(EC_TRUNC, key_number, key_wt, fin);
                end
                else if (phase == PH_VARVAL) begin
                    add_result(RK_SCALAR, key_number, key_wt, accum, 1'b0, EC_NONE);
                    go_key();
                end
                else begin
                    len = accum;
                    add_result(RK_HEADER, key_number, key_wt, len, 1'b0, EC_NONE);
                    clear_work();
                    if (len == 0)
                        phase = PH_KEY;
                    else begin
                        payload_left = len;
                        phase        = PH_PAYLOAD;
                        if (fin)
                            raise_error(EC_FIX_TRUNC, key_number, key_wt, fin);
                    end
                end
            end
            PH_FIXED: begin
                total = (key_wt == WT_FIXED64) ? 8 : 4;
                if (fixed_left == 0 || fixed_left > total)
                    fixed_left = total;
                pos = total - fixed_left;
                accum |= {56'd0, b} << (8 * (pos % 8));
                fixed_left--;
                if (fixed_left == 0) begin
                    add_result(RK_SCALAR, key_number, key_wt, accum, 1'b0, EC_NONE);
                    go_key();
                end
                else if (fin)
                    raise_error(EC_FIX_TRUNC, key_number, key_wt, fin);
            end
            PH_PAYLOAD: begin
                is_last_byte = (payload_left < 64'd2);
                add_result(RK_BYTE, key_number, key_wt, {56'd0, b}, is_last_byte, EC_NONE);
                if (is_last_byte)
                    go_key();
                else begin
                    payload_left--;
                    if (fin)
                        raise_error(EC_FIX_TRUNC, key_number, key_wt, fin);
                end
            end
            default: ;
        endcase
        if (fin)
            go_key();
        if (step_cnt > 0)
            step_res[step_cnt - 1].last_in_step = 1'b1;
        for (int i = 0; i < step_cnt; i++)
            owe_result(step_res[i]);
    endfunction

    task automatic compare_field(string name, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatch_count++;
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        results_owed   = 0;
        decoded_count  = 0;
        key_number     = '0;
        key_wt         = '0;
        go_key();
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            // compare the result handed over at this edge
            if (out_valid && !out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("result_kind: expected none, got 0x%0h", result_kind);
                    mismatch_count++;
                end
                else begin
                    want = owed_results.pop_front();
                    compare_field("result_kind", 64'(want.result_kind), 64'(result_kind));
                    compare_field("field_number", 64'(want.field_number), 64'(field_number));
                    compare_field("wire_kind", 64'(want.wire_kind), 64'(wire_kind));
                    compare_field("scalar_value", want.scalar_value, scalar_value);
                    compare_field("payload_last", 64'(want.payload_last), 64'(payload_last));
                    compare_field("error_code", 64'(want.error_code), 64'(error_code));
                    compare_field("last_in_step", 64'(want.last_in_step), 64'(last_in_step));
                end
            end
            // predict the results of the request taken at this edge
            if (in_valid && !in_stall) begin
                if (phase != PH_DRAIN)
                    decoded_count++;
                decode_byte(data_byte, message_end);
            end
            results_owed = owed_results.size();
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// Field parser testbench top: clock, reset, message stimulus, flow control and verdict.
module testbench
    import pwfp_pkg::*;
();

    localparam int ITEMS_PER_PHASE = 450;
    localparam int IDLE_LIMIT      = 2000;
    localparam int SETTLE_CYCLES   = 12;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte    = '0;
    logic        message_end  = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [1:0]  result_kind;
    logic [31:0] field_number;
    logic [2:0]  wire_kind;
    logic [63:0] scalar_value;
    logic        payload_last;
    logic [2:0]  error_code;
    logic        last_in_step;

    int          mismatch_count;
    int          results_owed;
    int          decoded_count;
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          idle_cycles    = 0;
    logic [7:0]  msg_q [$];

    protobuf_wire_field_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .field_number (field_number),
        .wire_kind    (wire_kind),
        .scalar_value (scalar_value),
        .payload_last (payload_last),
        .error_code   (error_code),
        .last_in_step (last_in_step)
    );

    wire_field_checker field_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .message_end    (message_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .field_number   (field_number),
        .wire_kind      (wire_kind),
        .scalar_value   (scalar_value),
        .payload_last   (payload_last),
        .error_code     (error_code),
        .last_in_step   (last_in_step),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed),
        .decoded_count  (decoded_count)
    );

    always
    begin
        #10;
        clk = 1'b1;
        #10;
        clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // End the run when no request moves on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one byte, with random gaps ahead of it, and hold it until taken
    task automatic send_byte(logic [7:0] b, logic fin);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        message_end <= fin;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Send n bytes, most significant first, the last one closing the message
    task automatic send_literal(logic [63:0] bytes, int n);
        for (int i = n - 1; i >= 0; i--)
            send_byte(bytes[8 * i +: 8], i == 0);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_byte(msg_q[i], i == msg_q.size() - 1);
        msg_q.delete();
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Add one byte to the end of the message being built
    function automatic void queue_byte(logic [7:0] b);
        msg_q = {msg_q, b};
    endfunction

    // Append a varint; nbytes above the shortest form pads with continuation bytes
    function automatic void put_varint(logic [63:0] v, int nbytes);
        logic [63:0] rest;
        int          n;
        n    = 1;
        rest = v >> 7;
        while (rest != 0) begin
            n++;
            rest = rest >> 7;
        end
        if (nbytes > n)
            n = nbytes;
        for (int i = 0; i < n; i++)
            queue_byte({1'(i < n - 1), 7'(v >> (7 * i))});
    endfunction

    // Append a key, now and then with bits above the field number or a padded form
    function automatic void put_key(logic [31:0] num, logic [2:0] wt);
        logic [28:0] hi;
        hi = ($urandom_range(15) == 0) ? 29'($urandom) : '0;
        put_varint({hi, num, wt}, ($urandom_range(7) == 0) ? $urandom_range(10) : 0);
    endfunction

    function automatic void put_junk(int n);
        repeat (n) queue_byte(8'($urandom));
    endfunction

    // Append a run of continuation bytes that overflows the varint limit
    function automatic void put_overlong();
        repeat (MAX_VARINT_BYTES) queue_byte(8'h80 | 8'($urandom_range(127)));
    endfunction

    function automatic logic [31:0] pick_number();
        logic [31:0] n;
        case ($urandom_range(3))
            0: return 32'($urandom_range(15, 1));
            1: return 32'($urandom_range(1 << 20, 16));
            2: return 32'hFFFF_FFFF;
            default:
            begin
                n = $urandom;
                return (n == 0) ? 32'd1 : n;
            end
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(4))
            0: return 64'($urandom_range(127));
            1: return '1;
            2: return '0;
            default: return {$urandom, $urandom} >> $urandom_range(63);
        endcase
    endfunction

    // Append one well-formed field with random content
    function automatic void add_good_field();
        logic [31:0] num;
        int          len;
        num = pick_number();
        case ($urandom_range(3))
            0: begin
                put_key(num, WT_VARINT);
                put_varint(pick_value(), ($urandom_range(7) == 0) ? $urandom_range(10) : 0);
            end
            1: begin
                put_key(num, WT_FIXED64);
                put_junk(8);
            end
            2: begin
                put_key(num, WT_FIXED32);
                put_junk(4);
            end
            default: begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
                put_key(num, WT_LEN);
                put_varint(64'(len), ($urandom_range(7) == 0) ? $urandom_range(10) : 0);
                put_junk(len);
            end
        endcase
    endfunction

    // Build one message: mostly well-formed, the rest cut short, broken or noise
    function automatic void build_message();
        int          pick;
        int          cut;
        logic [63:0] len;
        logic [28:0] hi;
        pick = $urandom_range(99);
        if (pick < 65)
            repeat ($urandom_range(4, 1)) add_good_field();
        else if (pick < 80) begin
            repeat ($urandom_range(3, 1)) add_good_field();
            if (msg_q.size() > 1) begin
                cut = $urandom_range(msg_q.size() - 1, 1);
                while (msg_q.size() > cut)
                    void'(msg_q.pop_back());
            end
        end
        else if (pick < 90) begin
            repeat ($urandom_range(2)) add_good_field();
            case ($urandom_range(5))
                0: put_key(pick_number(), $urandom_range(1) ? WT_GRP_START : WT_GRP_END);
                1: put_key(pick_number(), 3'($urandom_range(7, 6)));
                2: begin
                    hi = $urandom_range(1) ? 29'($urandom) : '0;
                    put_varint({hi, 32'd0, 3'($urandom)}, 0);
                end
                3: put_overlong();
                4: begin
                    put_key(pick_number(), WT_VARINT);
                    put_overlong();
                end
                default: begin
                    put_key(pick_number(), WT_LEN);
                    put_overlong();
                end
            endcase
            put_junk($urandom_range(4));
        end
        else if (pick < 95) begin
            // length larger than what the message still carries
            repeat ($urandom_range(1)) add_good_field();
            len = $urandom_range(3) ? 64'($urandom_range(28, 9)) : {$urandom, $urandom};
            if (len < 9)
                len = 9;
            put_key(pick_number(), WT_LEN);
            put_varint(len, 0);
            put_junk($urandom_range(8));
        end
        else
            put_junk($urandom_range(8, 1));
    endfunction

    task automatic run_phase(int gap_pct, int stall_pct);
        int goal;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        goal           = decoded_count + ITEMS_PER_PHASE;
        while (decoded_count < goal) begin
            build_message();
            send_message();
            if ($urandom_range(39) == 0)
                wait_results_drained();
        end
        wait_results_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed messages: extremes and each corner of the decoder
        send_gap_pct   = 18;
        recv_stall_pct = 51;
        send_literal(64'h08_00, 2);                 // varint value zero
        send_literal(64'h0D_FF_FF_FF_FF, 5);        // fixed32 all ones
        send_literal(64'h12_00_1A_02_AB_CD, 6);     // zero length, then a short payload
        send_literal(64'h00, 1);                    // field number zero on the last byte
        send_literal(64'h1B_55, 2);                 // group key, following byte dropped
        send_literal(64'h0E, 1);                    // bad wire type
        send_literal(64'h09, 1);                    // message ends after a fixed64 key
        send_literal(64'h80, 1);                    // message ends inside the key
        send_literal(64'h22_05_AA, 3);              // payload overrun
        send_literal(64'h08_80, 2);                 // message ends inside the value
        wait_results_drained();

        run_phase(18, 51);
        run_phase(51, 18);
        run_phase(0, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
